[rtl/assert_macros.svh]
// assertion macros for the rotated box bounds rtl
// expects i_clk and i_rst_n in the scope of each use; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RBB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rbb assertion failed");
// next-cycle implication
`define RBB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rbb assertion failed");
`else
`define RBB_ASSERT_IMPL(lbl, ante, cons)
`define RBB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/rbb_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and rounding helpers for the rotated box bounds block
// no dependencies
package rbb_pkg;

    // angle arithmetic, sixteenths of a degree
    localparam int ANGLE_W = 13;
    localparam logic [ANGLE_W-1:0] QUARTER_STEPS = 13'd1440;
    localparam logic [ANGLE_W-1:0] HALF_STEPS    = 13'd2880;
    localparam logic [ANGLE_W-1:0] THREEQ_STEPS  = 13'd4320;
    localparam logic [ANGLE_W-1:0] FULL_STEPS    = 13'd5760;
    localparam int REM_W = 11;

    // division by a quarter turn through a reciprocal, exact for r * entries < 2^23
    localparam int QPROD_W = 23;
    localparam int RECIP_SHIFT = 34;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam logic signed [MUL_B_W-1:0] RECIP_QUARTER = 25'sd11930465;

    // sine table entries, unsigned q1.16, and their signed form
    localparam int SIN_W  = 17;
    localparam int TRIG_W = SIN_W + 1;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // coordinate widths
    localparam int COORD_W = 32;
    localparam int SCALE_W = 24;
    localparam int VEC_W   = 40;
    localparam int ROT_W   = 41;
    localparam int WIDE_W  = ROT_W + 1;
    localparam logic signed [COORD_W-1:0] I32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] I32_MIN = 32'sh8000_0000;

    // configuration port
    localparam int PADDR_W     = 5;
    localparam int REG_IDX_LSB = 2;

    typedef enum logic [2:0] {
        REG_ANGLE,
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_SCALE_X,
        REG_SCALE_Y,
        REG_COORD_MODE
    } t_reg_idx;

    typedef struct packed {
        logic [ANGLE_W-1:0]        rotation_angle;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [SCALE_W-1:0] scale_x;
        logic signed [SCALE_W-1:0] scale_y;
        logic                      coord_mode;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        rotation_angle: '0,
        origin_x:       '0,
        origin_y:       '0,
        scale_x:        24'sd65536,
        scale_y:        24'sd65536,
        coord_mode:     1'b1
    };

    // sequencer steps of one corner
    typedef enum logic [3:0] {
        S_IDLE,
        S_P1,
        S_P2,
        S_IDX,
        S_VX,
        S_VY,
        S_SC,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_FIN
    } t_state;

    // round half up of a product by 2^16
    function automatic logic signed [PROD_W-17:0] round_prod(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = v + PROD_W'(32768);
        return t[PROD_W-1:16];
    endfunction

    // round half up of a sum of two products by 2^16
    function automatic logic signed [PROD_W-16:0] round_sum(input logic signed [PROD_W:0] v);
        logic signed [PROD_W:0] t;
        t = v + (PROD_W + 1)'(32768);
        return t[PROD_W:16];
    endfunction

    // saturate to 32 bits signed
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if ((&v[WIDE_W-1:COORD_W-1]) || !(|v[WIDE_W-1:COORD_W-1])) begin
            r = v[COORD_W-1:0];
        end else if (v[WIDE_W-1]) begin
            r = I32_MIN;
        end else begin
            r = I32_MAX;
        end
        return r;
    endfunction

endpackage

[rtl/rbb_mul.sv]
`timescale 1ns / 1ps
// shared signed multiplier with registered product
// depends on rbb_pkg
module rbb_mul import rbb_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [PROD_W-1:0]  o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // one product per cycle, result in the next cycle
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[rtl/rbb_sine_rom.sv]
`timescale 1ns / 1ps
// quarter-wave sine rom, contents built at elaboration, registered read
// depends on rbb_pkg
module rbb_sine_rom import rbb_pkg::*; #(
    parameter int SINE_TABLE_ENTRIES = 1440,
    localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1)
) (
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_addr,
    output logic [SIN_W-1:0] o_data
);

    typedef logic [SIN_W-1:0] t_rom [0:SINE_TABLE_ENTRIES];

    // fixed-point taylor series of sin over a quarter turn
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] rnd;
        for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
            x    = (PI_HALF_Q30 * 64'(i)) / SINE_TABLE_ENTRIES;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd342; sum = sum - $signed(term);
            if (sum < 0) begin
                sum = 0;
            end
            rnd = (sum + 64'sd8192) >>> 14;
            if (rnd > 64'sd65536) begin
                rnd = 64'sd65536;
            end
            rom[i] = rnd[SIN_W-1:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [SIN_W-1:0] r_data;

    // registered rom read
    always_ff @(posedge i_clk) begin
        r_data <= SINE_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

[rtl/rbb_cfg.sv]
`timescale 1ns / 1ps
// apb register file: rotation angle, origin, per-axis scale, output mode
// depends on rbb_pkg
module rbb_cfg import rbb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:REG_IDX_LSB]);
    assign w_wr   = psel && penable && pwrite;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_ANGLE:      n_cfg.rotation_angle = pwdata[ANGLE_W-1:0];
                REG_ORIGIN_X:   n_cfg.origin_x       = pwdata;
                REG_ORIGIN_Y:   n_cfg.origin_y       = pwdata;
                REG_SCALE_X:    n_cfg.scale_x        = pwdata[SCALE_W-1:0];
                REG_SCALE_Y:    n_cfg.scale_y        = pwdata[SCALE_W-1:0];
                REG_COORD_MODE: n_cfg.coord_mode     = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_ANGLE:      prdata = {{(32-ANGLE_W){1'b0}}, r_cfg.rotation_angle};
            REG_ORIGIN_X:   prdata = r_cfg.origin_x;
            REG_ORIGIN_Y:   prdata = r_cfg.origin_y;
            REG_SCALE_X:    prdata = {{(32-SCALE_W){1'b0}}, r_cfg.scale_x};
            REG_SCALE_Y:    prdata = {{(32-SCALE_W){1'b0}}, r_cfg.scale_y};
            REG_COORD_MODE: prdata = {31'd0, r_cfg.coord_mode};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/rotated_box_bounds.sv]
`timescale 1ns / 1ps
// rotated box bounds: corner transform with running axis-aligned bounding box
// Input channel s_axis: tdata carries one polygon corner (x, y, Q16.16), tlast
// marks the last corner. Output channel m_axis: tdata carries the transformed
// corner and the running box, tlast says the box is closed with this corner.
// Registers on the apb port set angle, origin, per-axis scale and output mode;
// write them only while no corner is in flight.
// Between acceptance and a loaded output register, each corner's
// six products (scale, rotate) and two for the angle-to-index step all go
// through one shared multiplier, one per cycle, plus two sine rom reads.
// s_axis_tready is high only while the sequencer is idle, so a corner is not
// taken before the last one is through. The output register lets the next
// corner be accepted while a result waits; if m_axis_tready stays low the
// sequencer holds in its last step until the register is free.
// Reset clears the sequencer, the output valid, the registers to their
// defaults and the box to its empty extremes. The sine rom is constant.
// depends on rbb_pkg, rbb_cfg, rbb_mul, rbb_sine_rom, assert_macros.svh
`include "assert_macros.svh"
module rotated_box_bounds import rbb_pkg::*; #(
    parameter int SINE_TABLE_ENTRIES = 1440
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // corner in: point_x [31:0], point_y [63:32]
    input  logic [63:0]        s_axis_tdata,
    input  logic               s_axis_tlast,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // result out: out_x [31:0], out_y [63:32], box_min_x [95:64],
    // box_min_y [127:96], box_max_x [159:128], box_max_y [191:160]
    output logic [191:0]       m_axis_tdata,
    output logic               m_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);

    t_cfg   w_cfg;
    t_state r_state;
    t_state n_state;

    // corner and intermediate registers
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic                      r_last;
    logic [1:0]                r_quad;
    logic [REM_W-1:0]          r_rem;
    logic [IDX_W-1:0]          r_idx;
    logic signed [VEC_W-1:0]   r_vx;
    logic signed [VEC_W-1:0]   r_vy;
    logic [SIN_W-1:0]          r_s0;
    logic signed [TRIG_W-1:0]  r_sn;
    logic signed [TRIG_W-1:0]  r_cs;
    logic signed [PROD_W-1:0]  r_acc;
    logic signed [ROT_W-1:0]   r_rx;
    logic signed [ROT_W-1:0]   r_ry;

    // box state
    logic signed [COORD_W-1:0] r_low_x;
    logic signed [COORD_W-1:0] r_low_y;
    logic signed [COORD_W-1:0] r_high_x;
    logic signed [COORD_W-1:0] r_high_y;

    // output register
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic                      r_out_last;
    logic signed [COORD_W-1:0] r_out_x;
    logic signed [COORD_W-1:0] r_out_y;
    logic signed [COORD_W-1:0] r_out_min_x;
    logic signed [COORD_W-1:0] r_out_min_y;
    logic signed [COORD_W-1:0] r_out_max_x;
    logic signed [COORD_W-1:0] r_out_max_y;

    logic                      w_in_acc;
    logic                      w_load;
    logic [ANGLE_W-1:0]        w_angle;
    logic [ANGLE_W-1:0]        w_base;
    logic [ANGLE_W-1:0]        w_rem_full;
    logic [1:0]                w_quad;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-17:0] w_prod_rnd;
    logic signed [PROD_W:0]    w_comb;
    logic signed [PROD_W-16:0] w_comb_rnd;
    logic [IDX_W-1:0]          w_rom_addr;
    logic [SIN_W-1:0]          w_rom;
    logic signed [TRIG_W-1:0]  w_s_pos;
    logic signed [TRIG_W-1:0]  w_c_pos;
    logic signed [TRIG_W-1:0]  w_sn;
    logic signed [TRIG_W-1:0]  w_cs;
    logic signed [COORD_W-1:0] w_wx;
    logic signed [COORD_W-1:0] w_wy;
    logic signed [COORD_W-1:0] w_ox;
    logic signed [COORD_W-1:0] w_oy;
    logic signed [COORD_W-1:0] w_min_x;
    logic signed [COORD_W-1:0] w_min_y;
    logic signed [COORD_W-1:0] w_max_x;
    logic signed [COORD_W-1:0] w_max_y;

    rbb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rbb_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    rbb_sine_rom #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom)
    );

    // angle wrap, quadrant and remainder within the quadrant
    always_comb begin
        w_angle = (w_cfg.rotation_angle >= FULL_STEPS) ?
                  (w_cfg.rotation_angle - FULL_STEPS) : w_cfg.rotation_angle;
        if (w_angle >= THREEQ_STEPS) begin
            w_quad = 2'd3;
            w_base = THREEQ_STEPS;
        end else if (w_angle >= HALF_STEPS) begin
            w_quad = 2'd2;
            w_base = HALF_STEPS;
        end else if (w_angle >= QUARTER_STEPS) begin
            w_quad = 2'd1;
            w_base = QUARTER_STEPS;
        end else begin
            w_quad = 2'd0;
            w_base = '0;
        end
        w_rem_full = w_angle - w_base;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (s_axis_tvalid) n_state = S_P1;
            S_P1:   n_state = S_P2;
            S_P2:   n_state = S_IDX;
            S_IDX:  n_state = S_VX;
            S_VX:   n_state = S_VY;
            S_VY:   n_state = S_SC;
            S_SC:   n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_M4;
            S_M4:   n_state = S_M5;
            S_M5:   n_state = S_FIN;
            S_FIN:  if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: handshake, multiplier operands, rom address
    always_comb begin
        s_axis_tready = 1'b0;
        w_load        = 1'b0;
        w_mul_a       = '0;
        w_mul_b       = '0;
        w_rom_addr    = r_idx;
        case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_P1: begin
                w_mul_a = MUL_A_W'(r_rem);
                w_mul_b = MUL_B_W'(SINE_TABLE_ENTRIES);
            end
            S_P2: begin
                w_mul_a = MUL_A_W'(w_prod[QPROD_W-1:0]);
                w_mul_b = RECIP_QUARTER;
            end
            S_IDX: begin
                w_mul_a = MUL_A_W'(r_px);
                w_mul_b = MUL_B_W'(w_cfg.scale_x);
            end
            S_VX: begin
                w_mul_a = MUL_A_W'(r_py);
                w_mul_b = MUL_B_W'(w_cfg.scale_y);
            end
            S_VY: w_rom_addr = IDX_W'(SINE_TABLE_ENTRIES) - r_idx;
            S_M1: begin
                w_mul_a = r_vx;
                w_mul_b = MUL_B_W'(r_cs);
            end
            S_M2: begin
                w_mul_a = r_vy;
                w_mul_b = MUL_B_W'(r_sn);
            end
            S_M3: begin
                w_mul_a = r_vx;
                w_mul_b = MUL_B_W'(r_sn);
            end
            S_M4: begin
                w_mul_a = r_vy;
                w_mul_b = MUL_B_W'(r_cs);
            end
            S_FIN: w_load = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // rounding of a scaled coordinate and of the rotation sums
    assign w_prod_rnd = round_prod(w_prod);
    assign w_comb     = (r_state == S_M3) ? ((PROD_W + 1)'(r_acc) - (PROD_W + 1)'(w_prod))
                                          : ((PROD_W + 1)'(r_acc) + (PROD_W + 1)'(w_prod));
    assign w_comb_rnd = round_sum(w_comb);

    // sine and cosine by quadrant
    assign w_s_pos = $signed({1'b0, r_s0});
    assign w_c_pos = $signed({1'b0, w_rom});
    always_comb begin
        case (r_quad)
            2'd0: begin
                w_sn = w_s_pos;
                w_cs = w_c_pos;
            end
            2'd1: begin
                w_sn = w_c_pos;
                w_cs = -w_s_pos;
            end
            2'd2: begin
                w_sn = -w_s_pos;
                w_cs = -w_c_pos;
            end
            default: begin
                w_sn = -w_c_pos;
                w_cs = w_s_pos;
            end
        endcase
    end

    // world coordinates, emitted corner and box including this corner
    always_comb begin
        w_wx    = sat32(WIDE_W'(r_rx) + WIDE_W'(w_cfg.origin_x));
        w_wy    = sat32(WIDE_W'(r_ry) + WIDE_W'(w_cfg.origin_y));
        w_ox    = w_cfg.coord_mode ? w_wx : sat32(WIDE_W'(r_rx));
        w_oy    = w_cfg.coord_mode ? w_wy : sat32(WIDE_W'(r_ry));
        w_min_x = (w_wx < r_low_x)  ? w_wx : r_low_x;
        w_min_y = (w_wy < r_low_y)  ? w_wy : r_low_y;
        w_max_x = (w_wx > r_high_x) ? w_wx : r_high_x;
        w_max_y = (w_wy > r_high_y) ? w_wy : r_high_y;
    end

    // datapath registers, one step per state
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_px   <= s_axis_tdata[31:0];
                    r_py   <= s_axis_tdata[63:32];
                    r_last <= s_axis_tlast;
                    r_quad <= w_quad;
                    r_rem  <= w_rem_full[REM_W-1:0];
                end
            end
            S_IDX: r_idx <= w_prod[RECIP_SHIFT +: IDX_W];
            S_VX:  r_vx  <= w_prod_rnd[VEC_W-1:0];
            S_VY: begin
                r_vy <= w_prod_rnd[VEC_W-1:0];
                r_s0 <= w_rom;
            end
            S_SC: begin
                r_sn <= w_sn;
                r_cs <= w_cs;
            end
            S_M2: r_acc <= w_prod;
            S_M3: r_rx  <= w_comb_rnd[ROT_W-1:0];
            S_M4: r_acc <= w_prod;
            S_M5: r_ry  <= w_comb_rnd[ROT_W-1:0];
            default: ;
        endcase
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_last  <= r_last;
            r_out_x     <= w_ox;
            r_out_y     <= w_oy;
            r_out_min_x <= w_min_x;
            r_out_min_y <= w_min_y;
            r_out_max_x <= w_max_x;
            r_out_max_y <= w_max_y;
        end
    end

    // output valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state and running box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_low_x     <= I32_MAX;
            r_low_y     <= I32_MAX;
            r_high_x    <= I32_MIN;
            r_high_y    <= I32_MIN;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_load) begin
                if (r_last) begin
                    r_low_x  <= I32_MAX;
                    r_low_y  <= I32_MAX;
                    r_high_x <= I32_MIN;
                    r_high_y <= I32_MIN;
                end else begin
                    r_low_x  <= w_min_x;
                    r_low_y  <= w_min_y;
                    r_high_x <= w_max_x;
                    r_high_y <= w_max_y;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {r_out_max_y, r_out_max_x, r_out_min_y, r_out_min_x,
                            r_out_y, r_out_x};

    // an accepted corner keeps the input closed while it is worked on
    `RBB_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // the reported box always contains the current corner's world coordinates, so it is never inverted
    `RBB_ASSERT_IMPL(a_box_ordered, m_axis_tvalid, (r_out_min_x <= r_out_max_x) && (r_out_min_y <= r_out_max_y))
    // closing a polygon returns the box to its empty extremes
    `RBB_ASSERT_NEXT(a_box_reopens, w_load && r_last, (r_low_x == I32_MAX) && (r_high_x == I32_MIN) && (r_low_y == I32_MAX) && (r_high_y == I32_MIN))

endmodule
